// File: design/force_directed_layout_step_core_assert.svh
// Assertion helpers used by the layout control module.
`ifndef FORCE_DIRECTED_LAYOUT_STEP_CORE_ASSERT_SVH
`define FORCE_DIRECTED_LAYOUT_STEP_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FDL_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FDL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: design/fdl_pkg.sv
`default_nettype none
package fdl_pkg;

    localparam int MAX_NODES = 64;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int LANES     = 3;

    typedef logic signed [31:0] t_word;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_EDGE,
        KIND_STEP,
        KIND_CLEAR
    } t_kind;

    typedef enum logic [2:0] {
        REG_NODE_COUNT,
        REG_REPULSION,
        REG_SPRING,
        REG_DAMPING,
        REG_GRAVITY
    } t_reg;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_ADJ_RD_N,
        DP_ADJ_WR_N,
        DP_ADJ_RD_O,
        DP_ADJ_WR_O,
        DP_RD,
        DP_NODE_CAP,
        DP_DIFF,
        DP_MUL,
        DP_SUM,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_REP_ACC,
        DP_FMUL1,
        DP_GRAV,
        DP_NET,
        DP_ACC,
        DP_FMUL2,
        DP_VEL,
        DP_FMUL3,
        DP_POS,
        DP_WB
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_E_RDN,
        ST_E_WRN,
        ST_E_RDO,
        ST_E_WRO,
        ST_ND_RD,
        ST_ND_CAP,
        ST_PR_RD,
        ST_PR_DIFF,
        ST_PR_MUL,
        ST_PR_SUM,
        ST_PR_DIVI,
        ST_PR_DIV,
        ST_PR_ACC,
        ST_N_MUL1,
        ST_N_GRAV,
        ST_N_NET,
        ST_N_ACC,
        ST_N_MUL2,
        ST_N_VEL,
        ST_N_MUL3,
        ST_N_POS,
        ST_WB
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             in_ready;
    } t_cmd;

    typedef struct packed {
        logic             in_valid;
        t_kind            kind;
        logic [CNT_W-1:0] node_lim;
        logic             r2_zero;
        logic             out_free;
    } t_sts;

    function automatic t_word sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return t_word'(v[31:0]);
    endfunction

    function automatic t_word sat_add(input t_word a, input t_word b);
        return sat64(64'(a) + 64'(b));
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        return sat64(64'(a) - 64'(b));
    endfunction

    function automatic logic [31:0] mag32(input t_word a);
        return a[31] ? 32'(-33'(a)) : 32'(a);
    endfunction

    // product scaled back by the fraction, truncated toward zero
    function automatic t_word mulq(input logic signed [63:0] p);
        logic signed [63:0] m;
        logic signed [63:0] s;
        m = p[63] ? -p : p;
        s = m >>> FRAC_BITS;
        return p[63] ? sat64(-s) : sat64(s);
    endfunction

endpackage
`default_nettype wire

// File: design/fdl_if.sv
`default_nettype none
interface fdl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  node_index;
    logic [5:0]  other_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0] time_step;

    modport source (output valid, kind, node_index, other_index, pos_x, pos_y, pos_z,
                    vel_x, vel_y, vel_z, time_step, input ready);
    modport sink (input valid, kind, node_index, other_index, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, time_step, output ready);
endinterface

interface fdl_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  out_index;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic        last;
    logic [31:0] step_count;

    modport source (output valid, out_index, new_pos_x, new_pos_y, new_pos_z,
                    new_vel_x, new_vel_y, new_vel_z, last, step_count, input ready);
    modport sink (input valid, out_index, new_pos_x, new_pos_y, new_pos_z,
                  new_vel_x, new_vel_y, new_vel_z, last, step_count, output ready);
endinterface

interface fdl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/fdl_ram.sv
`default_nettype none
module fdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/fdl_ctrl.sv
`default_nettype none
module fdl_ctrl import fdl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output      t_cmd o_cmd
);
    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_i, n_i;
    logic [IDX_W-1:0]     r_j, n_j;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 i_last, j_last;

    assign i_last = (CNT_W'(r_i) + CNT_W'(1)) == i_sts.node_lim;
    assign j_last = (CNT_W'(r_j) + CNT_W'(1)) == i_sts.node_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_i             = r_i;
        n_j             = r_j;
        n_cnt           = r_cnt;
        o_cmd.op        = DP_NOP;
        o_cmd.idx       = r_j;
        o_cmd.last      = 1'b0;
        o_cmd.in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    unique case (i_sts.kind)
                        KIND_LOAD:  n_state = ST_LOAD;
                        KIND_EDGE:  n_state = ST_E_RDN;
                        KIND_STEP: begin
                            n_i = '0;
                            if (i_sts.node_lim != '0) begin
                                n_state = ST_ND_RD;
                            end
                        end
                        KIND_CLEAR: n_state = ST_IDLE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                o_cmd.op = DP_LOAD;
                n_state  = ST_IDLE;
            end
            ST_E_RDN: begin
                o_cmd.op = DP_ADJ_RD_N;
                n_state  = ST_E_WRN;
            end
            ST_E_WRN: begin
                o_cmd.op = DP_ADJ_WR_N;
                n_state  = ST_E_RDO;
            end
            ST_E_RDO: begin
                o_cmd.op = DP_ADJ_RD_O;
                n_state  = ST_E_WRO;
            end
            ST_E_WRO: begin
                o_cmd.op = DP_ADJ_WR_O;
                n_state  = ST_IDLE;
            end
            ST_ND_RD: begin
                o_cmd.op  = DP_RD;
                o_cmd.idx = r_i;
                n_state   = ST_ND_CAP;
            end
            ST_ND_CAP: begin
                o_cmd.op  = DP_NODE_CAP;
                o_cmd.idx = r_i;
                n_j       = '0;
                n_state   = ST_PR_RD;
            end
            ST_PR_RD: begin
                // skip the node itself
                if (r_j == r_i) begin
                    if (j_last) begin
                        n_state = ST_N_MUL1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    o_cmd.op = DP_RD;
                    n_state  = ST_PR_DIFF;
                end
            end
            ST_PR_DIFF: begin
                o_cmd.op = DP_DIFF;
                n_state  = ST_PR_MUL;
            end
            ST_PR_MUL: begin
                o_cmd.op = DP_MUL;
                n_state  = ST_PR_SUM;
            end
            ST_PR_SUM: begin
                o_cmd.op = DP_SUM;
                n_state  = ST_PR_DIVI;
            end
            ST_PR_DIVI: begin
                if (i_sts.r2_zero) begin
                    if (j_last) begin
                        n_state = ST_N_MUL1;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ST_PR_RD;
                    end
                end else begin
                    o_cmd.op = DP_DIV_INIT;
                    n_cnt    = '0;
                    n_state  = ST_PR_DIV;
                end
            end
            ST_PR_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_PR_ACC;
                end
            end
            ST_PR_ACC: begin
                o_cmd.op = DP_REP_ACC;
                if (j_last) begin
                    n_state = ST_N_MUL1;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_PR_RD;
                end
            end
            ST_N_MUL1: begin
                o_cmd.op = DP_FMUL1;
                n_state  = ST_N_GRAV;
            end
            ST_N_GRAV: begin
                o_cmd.op = DP_GRAV;
                n_state  = ST_N_NET;
            end
            ST_N_NET: begin
                o_cmd.op = DP_NET;
                n_state  = ST_N_ACC;
            end
            ST_N_ACC: begin
                o_cmd.op = DP_ACC;
                n_state  = ST_N_MUL2;
            end
            ST_N_MUL2: begin
                o_cmd.op = DP_FMUL2;
                n_state  = ST_N_VEL;
            end
            ST_N_VEL: begin
                o_cmd.op = DP_VEL;
                n_state  = ST_N_MUL3;
            end
            ST_N_MUL3: begin
                o_cmd.op = DP_FMUL3;
                n_state  = ST_N_POS;
            end
            ST_N_POS: begin
                o_cmd.op = DP_POS;
                n_state  = ST_WB;
            end
            ST_WB: begin
                o_cmd.idx  = r_i;
                o_cmd.last = i_last;
                // hold until the output register can take the node
                if (i_sts.out_free) begin
                    o_cmd.op = DP_WB;
                    if (i_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_ND_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`include "force_directed_layout_step_core_assert.svh"

    `FDL_ASSERT_NEXT(a_div_done, (r_state == ST_PR_DIV) && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)), r_state == ST_PR_ACC, "divider did not finish after its last step")
    `FDL_ASSERT_NEXT(a_step_end, (r_state == ST_WB) && i_sts.out_free && i_last, r_state == ST_IDLE, "step did not end after final node")
    `FDL_ASSERT_NOW(a_no_self_pair, r_state == ST_PR_DIFF, r_j != r_i, "node paired with itself")

endmodule
`default_nettype wire

// File: design/fdl_dp.sv
`default_nettype none
module fdl_dp import fdl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fdl_in_if.sink    i_in,
    fdl_out_if.source o_out,
    fdl_cfg_if.sink   i_cfg,
    input  wire t_cmd i_cmd,
    output      t_sts o_sts
);
    // configuration
    logic [6:0] r_node_count;
    t_word      r_rep_gain, r_spr_gain, r_dmp_gain, r_grv_gain;

    // captured item
    logic [IDX_W-1:0] r_ni, r_oi;
    t_word            r_ld_pos [LANES];
    t_word            r_ld_vel [LANES];
    logic [30:0]      r_dt;
    logic [31:0]      r_iter;

    // node and pair working registers
    t_word              r_pi [LANES];
    t_word              r_vi [LANES];
    logic [MAX_NODES-1:0] r_adj;
    logic [MAX_NODES-1:0] r_adj_vld;
    t_word              r_d [LANES];
    logic               r_neg [LANES];
    logic [63:0]        r_sq [LANES];
    logic [63:0]        r_num [LANES];
    logic signed [63:0] r_sp [LANES];
    logic [63:0]        r_r2;
    t_word              r_fspr [LANES];
    t_word              r_frep [LANES];
    logic signed [63:0] r_prod [LANES];
    logic signed [63:0] r_prod2 [LANES];
    t_word              r_net [LANES];
    t_word              r_nv [LANES];
    t_word              r_np [LANES];
    logic [63:0]        r_rem [LANES];
    logic [31:0]        r_lo [LANES];
    logic [31:0]        r_q [LANES];
    logic               r_dsat [LANES];

    // output register
    logic        r_out_vld;
    logic [IDX_W-1:0] r_out_idx;
    t_word       r_out_pos [LANES];
    t_word       r_out_vel [LANES];
    logic        r_out_last;
    logic [31:0] r_out_cnt;

    // memories
    logic             pos_we, vel_we;
    logic [IDX_W-1:0] pv_waddr;
    t_word            pos_wdata [LANES];
    t_word            vel_wdata [LANES];
    logic [31:0]      pos_rdata [LANES];
    logic [31:0]      vel_rdata [LANES];
    logic             adj_we;
    logic [IDX_W-1:0] adj_waddr, adj_raddr;
    logic [MAX_NODES-1:0] adj_wdata, adj_rdata, adj_row;
    logic             in_acc, ld_ok, edge_ok;
    logic [31:0]      rep_mag;

    assign in_acc  = i_in.valid && i_in.ready;
    assign ld_ok   = 32'(r_ni) < MAX_NODES;
    assign edge_ok = (r_ni != r_oi) && (32'(r_ni) < MAX_NODES) && (32'(r_oi) < MAX_NODES);
    assign rep_mag = mag32(r_rep_gain);

    assign i_in.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_sts.in_valid = i_in.valid;
    assign o_sts.kind     = t_kind'(i_in.kind);
    assign o_sts.node_lim = (32'(r_node_count) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                             : CNT_W'(r_node_count);
    assign o_sts.r2_zero  = r_r2 == '0;
    assign o_sts.out_free = !r_out_vld || o_out.ready;

    assign pos_we   = ((i_cmd.op == DP_LOAD) && ld_ok) || (i_cmd.op == DP_WB);
    assign vel_we   = pos_we;
    assign pv_waddr = (i_cmd.op == DP_LOAD) ? r_ni : i_cmd.idx;

    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            pos_wdata[c] = (i_cmd.op == DP_LOAD) ? r_ld_pos[c] : r_np[c];
            vel_wdata[c] = (i_cmd.op == DP_LOAD) ? r_ld_vel[c] : r_nv[c];
        end
    end

    always_comb begin
        adj_raddr = i_cmd.idx;
        adj_waddr = r_ni;
        adj_row   = '0;
        adj_we    = 1'b0;
        unique case (i_cmd.op)
            DP_ADJ_RD_N: adj_raddr = r_ni;
            DP_ADJ_RD_O: adj_raddr = r_oi;
            DP_ADJ_WR_N: begin
                adj_waddr = r_ni;
                adj_row   = r_adj_vld[r_ni] ? adj_rdata : '0;
                adj_we    = edge_ok;
            end
            DP_ADJ_WR_O: begin
                adj_waddr = r_oi;
                adj_row   = r_adj_vld[r_oi] ? adj_rdata : '0;
                adj_we    = edge_ok;
            end
            default: adj_raddr = i_cmd.idx;
        endcase
        adj_wdata = adj_row | (MAX_NODES'(1) << ((i_cmd.op == DP_ADJ_WR_N) ? r_oi : r_ni));
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane_ram
        fdl_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_pos (
            .i_clk   (i_clk),
            .i_we    (pos_we),
            .i_waddr (pv_waddr),
            .i_wdata (pos_wdata[g]),
            .i_raddr (i_cmd.idx),
            .o_rdata (pos_rdata[g])
        );
        fdl_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_vel (
            .i_clk   (i_clk),
            .i_we    (vel_we),
            .i_waddr (pv_waddr),
            .i_wdata (vel_wdata[g]),
            .i_raddr (i_cmd.idx),
            .o_rdata (vel_rdata[g])
        );
    end

    fdl_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_rep_gain   <= 32'sd65536;
            r_spr_gain   <= 32'sd65536;
            r_dmp_gain   <= 32'sd65536;
            r_grv_gain   <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_reg'(i_cfg.index))
                REG_NODE_COUNT: r_node_count <= i_cfg.data[6:0];
                REG_REPULSION:  r_rep_gain   <= t_word'(i_cfg.data);
                REG_SPRING:     r_spr_gain   <= t_word'(i_cfg.data);
                REG_DAMPING:    r_dmp_gain   <= t_word'(i_cfg.data);
                REG_GRAVITY:    r_grv_gain   <= t_word'(i_cfg.data);
                default:        r_node_count <= r_node_count;
            endcase
        end
    end

    // control state: counter, row valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter    <= '0;
            r_adj_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc && (t_kind'(i_in.kind) == KIND_STEP)) begin
                r_iter <= r_iter + 32'd1;
            end else if (in_acc && (t_kind'(i_in.kind) == KIND_CLEAR)) begin
                r_iter    <= '0;
                r_adj_vld <= '0;
            end
            if (adj_we) begin
                r_adj_vld[adj_waddr] <= 1'b1;
            end
            if (i_cmd.op == DP_WB) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ni        <= i_in.node_index;
            r_oi        <= i_in.other_index;
            r_ld_pos[0] <= i_in.pos_x;
            r_ld_pos[1] <= i_in.pos_y;
            r_ld_pos[2] <= i_in.pos_z;
            r_ld_vel[0] <= i_in.vel_x;
            r_ld_vel[1] <= i_in.vel_y;
            r_ld_vel[2] <= i_in.vel_z;
            r_dt        <= i_in.time_step;
        end
    end

    // arithmetic lanes
    always_ff @(posedge i_clk) begin
        logic [64:0]        t;
        logic               ge;
        logic [32:0]        qm;
        logic signed [63:0] v;
        t_word              nd;
        unique case (i_cmd.op)
            DP_NODE_CAP: begin
                r_adj <= r_adj_vld[i_cmd.idx] ? adj_rdata : '0;
                for (int c = 0; c < LANES; c++) begin
                    r_pi[c]   <= t_word'(pos_rdata[c]);
                    r_vi[c]   <= t_word'(vel_rdata[c]);
                    r_fspr[c] <= '0;
                    r_frep[c] <= '0;
                end
            end
            DP_DIFF: begin
                for (int c = 0; c < LANES; c++) begin
                    r_d[c] <= sat_sub(r_pi[c], t_word'(pos_rdata[c]));
                end
            end
            DP_MUL: begin
                for (int c = 0; c < LANES; c++) begin
                    nd        = sat_sub('0, r_d[c]);
                    r_sq[c]   <= 64'(mag32(r_d[c])) * 64'(mag32(r_d[c]));
                    r_num[c]  <= 64'(rep_mag) * 64'(mag32(r_d[c]));
                    r_sp[c]   <= 64'(r_spr_gain) * 64'(nd);
                    r_neg[c]  <= r_rep_gain[31] != r_d[c][31];
                end
            end
            DP_SUM: begin
                r_r2 <= r_sq[0] + r_sq[1] + r_sq[2];
                if (r_adj[i_cmd.idx]) begin
                    for (int c = 0; c < LANES; c++) begin
                        r_fspr[c] <= sat_add(r_fspr[c], mulq(r_sp[c]));
                    end
                end
            end
            DP_DIV_INIT: begin
                for (int c = 0; c < LANES; c++) begin
                    r_rem[c]  <= r_num[c] >> (32 - FRAC_BITS);
                    r_dsat[c] <= (r_num[c] >> (32 - FRAC_BITS)) >= r_r2;
                    r_lo[c]   <= 32'(r_num[c] << FRAC_BITS);
                    r_q[c]    <= '0;
                end
            end
            DP_DIV_STEP: begin
                // one quotient bit per lane
                for (int c = 0; c < LANES; c++) begin
                    t        = {r_rem[c], r_lo[c][31]};
                    ge       = t >= {1'b0, r_r2};
                    r_rem[c] <= ge ? 64'(t - {1'b0, r_r2}) : t[63:0];
                    r_q[c]   <= {r_q[c][30:0], ge};
                    r_lo[c]  <= {r_lo[c][30:0], 1'b0};
                end
            end
            DP_REP_ACC: begin
                for (int c = 0; c < LANES; c++) begin
                    qm = (r_dsat[c] || (r_q[c] > 32'h80000000)) ? 33'h080000000
                                                                 : {1'b0, r_q[c]};
                    v  = r_neg[c] ? -64'(qm) : 64'(qm);
                    r_frep[c] <= sat_add(r_frep[c], sat64(v));
                end
            end
            DP_FMUL1: begin
                for (int c = 0; c < LANES; c++) begin
                    r_prod[c]  <= 64'(r_grv_gain) * 64'(r_pi[c]);
                    r_prod2[c] <= 64'(r_vi[c]) * 64'(r_dmp_gain);
                end
            end
            DP_GRAV: begin
                for (int c = 0; c < LANES; c++) begin
                    r_fspr[c] <= sat_sub(r_fspr[c], mulq(r_prod[c]));
                end
            end
            DP_NET: begin
                for (int c = 0; c < LANES; c++) begin
                    r_net[c] <= sat_add(r_fspr[c], r_frep[c]);
                end
            end
            DP_ACC: begin
                for (int c = 0; c < LANES; c++) begin
                    r_net[c] <= sat_sub(r_net[c], mulq(r_prod2[c]));
                end
            end
            DP_FMUL2: begin
                for (int c = 0; c < LANES; c++) begin
                    r_prod[c] <= 64'(r_net[c]) * $signed({33'd0, r_dt});
                end
            end
            DP_VEL: begin
                for (int c = 0; c < LANES; c++) begin
                    r_nv[c] <= sat_add(r_vi[c], mulq(r_prod[c]));
                end
            end
            DP_FMUL3: begin
                for (int c = 0; c < LANES; c++) begin
                    r_prod[c] <= 64'(r_nv[c]) * $signed({33'd0, r_dt});
                end
            end
            DP_POS: begin
                for (int c = 0; c < LANES; c++) begin
                    r_np[c] <= sat_add(r_pi[c], mulq(r_prod[c]));
                end
            end
            DP_WB: begin
                r_out_idx  <= i_cmd.idx;
                r_out_last <= i_cmd.last;
                r_out_cnt  <= r_iter;
                for (int c = 0; c < LANES; c++) begin
                    r_out_pos[c] <= r_np[c];
                    r_out_vel[c] <= r_nv[c];
                end
            end
            default: r_r2 <= r_r2;
        endcase
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_index  = 6'(r_out_idx);
    assign o_out.new_pos_x  = r_out_pos[0];
    assign o_out.new_pos_y  = r_out_pos[1];
    assign o_out.new_pos_z  = r_out_pos[2];
    assign o_out.new_vel_x  = r_out_vel[0];
    assign o_out.new_vel_y  = r_out_vel[1];
    assign o_out.new_vel_z  = r_out_vel[2];
    assign o_out.last       = r_out_last;
    assign o_out.step_count = r_out_cnt;

endmodule
`default_nettype wire

// File: design/force_directed_layout_step_core.sv
// 3D spring-electrical layout engine in signed Q16.16. Load, edge and clear items
// return nothing. A step item walks the nodes in index order and emits one item
// per node with its new position and velocity; each node makes one pass per
// other node, and a pass is shorter when the two nodes coincide, since the
// bit-serial divider, which produces one quotient bit per cycle in each of its
// three lanes, is then skipped. A result waiting at the output holds the engine
// only at the end of the next node.
`default_nettype none
module force_directed_layout_step_core import fdl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fdl_in_if.sink    i_in,
    fdl_out_if.source o_out,
    fdl_cfg_if.sink   i_cfg
);
    t_cmd cmd;
    t_sts sts;

    fdl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fdl_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );
endmodule
`default_nettype wire
